// ----- hw/rtl/ibcs_pkg.sv -----
// shared types and constants for the i2c bus clear sequencer
// used by ibcs_core and i2c_bus_clear_sequencer; no dependencies
package ibcs_pkg;

    localparam logic [3:0]  MAX_PULSES            = 4'd9;
    localparam logic [15:0] HALF_PERIOD_RESET     = 16'd5;
    localparam logic [15:0] STRETCH_TIMEOUT_RESET = 16'd1000;

    localparam int TDATA_W = 8;

    typedef enum logic [0:0] {
        CFG_HALF_PERIOD     = 1'b0,
        CFG_STRETCH_TIMEOUT = 1'b1
    } cfg_idx_t;

    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_WAIT0  = 10'b00_0000_0010,
        PH_PLOW   = 10'b00_0000_0100,
        PH_PWAIT  = 10'b00_0000_1000,
        PH_PHIGH  = 10'b00_0001_0000,
        PH_STOP_A = 10'b00_0010_0000,
        PH_STOP_B = 10'b00_0100_0000,
        PH_STOP_C = 10'b00_1000_0000,
        PH_STOP_D = 10'b01_0000_0000,
        PH_STOP_E = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [15:0] stretch_timeout_ticks;
        logic [15:0] half_period_ticks;
    } cfg_t;

    // lowest bit first: start_req, sda_level, scl_level
    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic start_req;
    } in_t;

    // lowest bit first: scl_drive_low .. success
    typedef struct packed {
        logic success;
        logic done_res;
        logic busy_res;
        logic pullups_on;
        logic sda_drive_low;
        logic scl_drive_low;
    } res_t;

endpackage

// ----- hw/rtl/ibcs_core.sv -----
// sequencer state and per-tick next-state logic for the i2c bus clear
// depends on ibcs_pkg
module ibcs_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  ibcs_pkg::in_t  item,
    input  ibcs_pkg::cfg_t cfg,
    output ibcs_pkg::res_t res
);
    import ibcs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pcnt_reg, pcnt_next;
    logic [15:0] timer_reg, timer_next;

    logic [15:0] hp_lim, to_lim, timer_inc;
    logic [3:0]  pcnt_inc;
    logic        hp_exp, to_exp, done, ok;

    assign hp_lim    = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
    assign to_lim    = (cfg.stretch_timeout_ticks == 16'd0) ? 16'd1
                                                            : cfg.stretch_timeout_ticks;
    assign timer_inc = timer_reg + 16'd1;
    assign hp_exp    = ({1'b0, timer_reg} + 17'd1) >= {1'b0, hp_lim};
    assign to_exp    = ({1'b0, timer_reg} + 17'd1) >= {1'b0, to_lim};
    assign pcnt_inc  = pcnt_reg + 4'd1;

    always_comb begin
        phase_next = phase_reg;
        pcnt_next  = pcnt_reg;
        timer_next = timer_reg;
        done       = 1'b0;
        ok         = 1'b0;
        case (phase_reg)
            PH_WAIT0, PH_PWAIT, PH_STOP_C: begin
                if (item.scl_level) begin
                    timer_next = 16'd0;
                    if (phase_reg == PH_WAIT0) begin
                        phase_next = (!item.sda_level && pcnt_reg < MAX_PULSES) ? PH_PLOW
                                                                                 : PH_STOP_A;
                    end else if (phase_reg == PH_PWAIT) begin
                        phase_next = PH_PHIGH;
                    end else begin
                        phase_next = PH_STOP_D;
                    end
                end else if (to_exp) begin
                    timer_next = 16'd0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end else begin
                    timer_next = timer_inc;
                end
            end
            PH_PLOW, PH_STOP_A, PH_STOP_B, PH_STOP_D: begin
                if (hp_exp) begin
                    timer_next = 16'd0;
                    case (phase_reg)
                        PH_PLOW:   phase_next = PH_PWAIT;
                        PH_STOP_A: phase_next = PH_STOP_B;
                        PH_STOP_B: phase_next = PH_STOP_C;
                        default:   phase_next = PH_STOP_E;
                    endcase
                end else begin
                    timer_next = timer_inc;
                end
            end
            PH_PHIGH: begin
                if (hp_exp) begin
                    timer_next = 16'd0;
                    pcnt_next  = pcnt_inc;
                    phase_next = (!item.sda_level && pcnt_inc < MAX_PULSES) ? PH_PLOW
                                                                             : PH_STOP_A;
                end else begin
                    timer_next = timer_inc;
                end
            end
            PH_STOP_E: begin
                if (hp_exp) begin
                    timer_next = 16'd0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                    ok         = item.sda_level && item.scl_level;
                end else begin
                    timer_next = timer_inc;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                timer_next = 16'd0;
                if (item.start_req) begin
                    pcnt_next  = 4'd0;
                    phase_next = PH_WAIT0;
                end
            end
        endcase
    end

    always_comb begin
        res.scl_drive_low = (phase_next == PH_PLOW) || (phase_next == PH_STOP_A)
                         || (phase_next == PH_STOP_B);
        res.sda_drive_low = (phase_next == PH_STOP_B) || (phase_next == PH_STOP_C)
                         || (phase_next == PH_STOP_D);
        res.pullups_on    = (phase_next != PH_IDLE);
        res.busy_res      = (phase_next != PH_IDLE);
        res.done_res      = done;
        res.success       = done && ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pcnt_reg  <= 4'd0;
            timer_reg <= 16'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            pcnt_reg  <= pcnt_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// ----- hw/rtl/i2c_bus_clear_sequencer.sv -----
// top level of the i2c bus clear sequencer: stream channels, config registers
// depends on ibcs_pkg and ibcs_core
//
// usage:
//   each item on the s_ channel is one time tick with start_req and the
//   sampled sda and scl levels; each tick gives exactly one item on the m_
//   channel with the pin drives, pullups_on, busy_res, done_res and success
//   as they stand after that tick.
//   a start_req tick from idle runs the recovery: wait for scl high, up to
//   nine scl pulses while sda reads low, then a stop, then a final line check.
//   every wait for scl high is bounded by stretch_timeout_ticks; a timeout
//   releases the bus and reports done with success low.
//   an accepted tick goes through the input register, then the result
//   register. throughput: one tick per cycle while the receiver does not stall,
//   since the whole state update fits between the two registers.
//   if the receiver stalls, the result register holds and the input register
//   takes one more tick only if it is empty; s_tready stays low until m_tready returns.
//   reset (aresetn low, synchronous) returns to idle and loads the register
//   defaults: half_period_ticks 5, stretch_timeout_ticks 1000.
//   config writes (index 0 half_period_ticks, 1 stretch_timeout_ticks) are
//   taken on any cycle with cfg_wr_en high and are meant for idle periods.
module i2c_bus_clear_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ibcs_pkg::TDATA_W-1:0]  s_tdata,  // start_req, sda_level, scl_level
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ibcs_pkg::TDATA_W-1:0]  m_tdata,  // scl_drive_low, sda_drive_low,
                                                    // pullups_on, busy_res, done_res,
                                                    // success
    input  logic                          cfg_wr_en,
    input  ibcs_pkg::cfg_idx_t            cfg_addr,
    input  logic [15:0]                   cfg_wdata
);
    import ibcs_pkg::*;

    cfg_t cfg_reg;
    in_t  in_item_reg;
    res_t out_res_reg, res;
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, step_en, s_accept;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step_en;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !step_en);
    assign out_valid_next = step_en || (out_valid_reg && !m_tready);

    ibcs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.half_period_ticks     <= HALF_PERIOD_RESET;
            cfg_reg.stretch_timeout_ticks <= STRETCH_TIMEOUT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_HALF_PERIOD:     cfg_reg.half_period_ticks     <= cfg_wdata;
                    CFG_STRETCH_TIMEOUT: cfg_reg.stretch_timeout_ticks <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_tdata[2:0];
        end
        if (step_en) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

endmodule

// ----- hw/rtl/ibcs_chk.sv -----
// port-level assertions for i2c_bus_clear_sequencer, attached by bind
// depends on i2c_bus_clear_sequencer ports only
module ibcs_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    // success only together with done
    a_success_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[4])
        else $error("success without done");

    // the finishing tick no longer reports busy or pullups_on
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[3] && !m_tdata[2])
        else $error("done while busy");

    // line drives only while a sequence runs
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[0] || m_tdata[1]) |-> m_tdata[3] && m_tdata[2])
        else $error("line driven while idle");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

endmodule

bind i2c_bus_clear_sequencer ibcs_chk u_ibcs_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
